/* src/alle_pkg.sv */
`timescale 1ns / 1ps

package alle_pkg;

  localparam int unsigned PoolDepth = 1024;
  localparam int unsigned DataW     = 32;
  localparam int unsigned AddrW     = $clog2(PoolDepth);
  localparam int unsigned LinkW     = AddrW + 1;

  localparam logic [LinkW-1:0] NullLink = LinkW'(PoolDepth);

  localparam logic [1:0] OpInsert = 2'd0;
  localparam logic [1:0] OpErase  = 2'd1;
  localparam logic [1:0] OpRead   = 2'd2;

  localparam logic [1:0] StOk   = 2'd0;
  localparam logic [1:0] StFull = 2'd1;
  localparam logic [1:0] StBad  = 2'd2;

  typedef struct packed {
    logic             re;
    logic [AddrW-1:0] raddr;
    logic             we;
    logic [AddrW-1:0] waddr;
    logic [LinkW-1:0] wdata;
  } link_req_t;

  typedef struct packed {
    logic             re;
    logic [AddrW-1:0] raddr;
    logic             we;
    logic [AddrW-1:0] waddr;
    logic [DataW-1:0] wdata;
  } val_req_t;

endpackage

/* src/alle_in_if.sv */
`timescale 1ns / 1ps

interface alle_in_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  opcode;
  logic        [9:0]  node_addr;
  logic signed [31:0] item_value;

  modport source (output valid, output opcode, output node_addr, output item_value,
                  input ready);
  modport sink (input valid, input opcode, input node_addr, input item_value,
                output ready);
endinterface

/* src/alle_out_if.sv */
`timescale 1ns / 1ps

interface alle_out_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  status;
  logic        [9:0]  new_node;
  logic signed [31:0] read_value;
  logic        [9:0]  next_node;
  logic               next_is_null;
  logic        [9:0]  prev_node;

  modport source (output valid, output status, output new_node, output read_value,
                  output next_node, output next_is_null, output prev_node,
                  input ready);
  modport sink (input valid, input status, input new_node, input read_value,
                input next_node, input next_is_null, input prev_node,
                output ready);
endinterface

/* src/array_linked_list_engine.sv */
`timescale 1ns / 1ps
// Channel  Dir  Handshake      Transaction
// in_i     in   valid/ready    opcode, node_addr, item_value
// out_o    out  valid/ready    status, new_node, read_value, next_node, next_is_null, prev_node
//
// One transaction at a time. Insert passes through the accept, link and fix steps; erase,
// read and rejected requests pass through accept and link only.
// The single write port of each link RAM sets the extra fix step of insert.
// Reset: allocator at 1, head link reads null; no clearing pass.
// A result waiting on out_o.ready does not block the next accept; the engine stalls
// only at the last step of an item while the previous result is still held.

module array_linked_list_engine (
  input  logic       clk_i,
  input  logic       rst_ni,
  alle_in_if.sink    in_i,
  alle_out_if.source out_o
);

  alle_pkg::link_req_t           next_req;
  alle_pkg::link_req_t           prev_req;
  alle_pkg::val_req_t            val_req;
  logic [alle_pkg::LinkW-1:0]    next_rdata;
  logic [alle_pkg::LinkW-1:0]    prev_rdata;
  logic [alle_pkg::DataW-1:0]    val_rdata;

  alle_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .out_o        (out_o),
    .next_req_o   (next_req),
    .prev_req_o   (prev_req),
    .val_req_o    (val_req),
    .next_rdata_i (next_rdata),
    .prev_rdata_i (prev_rdata),
    .val_rdata_i  (val_rdata)
  );

  alle_ram #(.Width(alle_pkg::LinkW), .Depth(alle_pkg::PoolDepth)) u_next_ram (
    .clk_i   (clk_i),
    .we_i    (next_req.we),
    .waddr_i (next_req.waddr),
    .wdata_i (next_req.wdata),
    .re_i    (next_req.re),
    .raddr_i (next_req.raddr),
    .rdata_o (next_rdata)
  );

  alle_ram #(.Width(alle_pkg::LinkW), .Depth(alle_pkg::PoolDepth)) u_prev_ram (
    .clk_i   (clk_i),
    .we_i    (prev_req.we),
    .waddr_i (prev_req.waddr),
    .wdata_i (prev_req.wdata),
    .re_i    (prev_req.re),
    .raddr_i (prev_req.raddr),
    .rdata_o (prev_rdata)
  );

  alle_ram #(.Width(alle_pkg::DataW), .Depth(alle_pkg::PoolDepth)) u_val_ram (
    .clk_i   (clk_i),
    .we_i    (val_req.we),
    .waddr_i (val_req.waddr),
    .wdata_i (val_req.wdata),
    .re_i    (val_req.re),
    .raddr_i (val_req.raddr),
    .rdata_o (val_rdata)
  );

endmodule

/* src/alle_ram.sv */
`timescale 1ns / 1ps

module alle_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/alle_ctrl.sv */
`timescale 1ns / 1ps

module alle_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  alle_in_if.sink                       in_i,
  alle_out_if.source                    out_o,
  output alle_pkg::link_req_t           next_req_o,
  output alle_pkg::link_req_t           prev_req_o,
  output alle_pkg::val_req_t            val_req_o,
  input  logic [alle_pkg::LinkW-1:0]    next_rdata_i,
  input  logic [alle_pkg::LinkW-1:0]    prev_rdata_i,
  input  logic [alle_pkg::DataW-1:0]    val_rdata_i
);

  localparam logic [1:0] SIdle = 2'd0;
  localparam logic [1:0] SLink = 2'd1;
  localparam logic [1:0] SFix  = 2'd2;

  logic [1:0]                 state_q, state_d;
  logic [1:0]                 op_q;
  logic [alle_pkg::AddrW-1:0] addr_q;
  logic [alle_pkg::DataW-1:0] val_q;
  logic [1:0]                 st_q, st_d;
  logic [alle_pkg::LinkW-1:0] alloc_q, alloc_d;
  logic [alle_pkg::LinkW-1:0] succ_q;
  logic                       head_wr_q;

  logic                       out_valid_q;
  logic [1:0]                 o_status_q, o_status_d;
  logic [9:0]                 o_new_q, o_new_d;
  logic [31:0]                o_val_q, o_val_d;
  logic [9:0]                 o_next_q, o_next_d;
  logic                       o_null_q, o_null_d;
  logic [9:0]                 o_prev_q, o_prev_d;

  logic                       accept;
  logic                       out_free;
  logic                       finish;
  logic [alle_pkg::LinkW-1:0] next_rd;
  logic                       next_ok, prev_ok, succ_ok;
  logic [alle_pkg::AddrW-1:0] fresh;
  logic [alle_pkg::LinkW-1:0] in_addr_ext;

  assign in_i.ready  = (state_q == SIdle);
  assign accept      = in_i.valid && in_i.ready;
  assign out_free    = !out_valid_q || out_o.ready;
  assign fresh       = alloc_q[alle_pkg::AddrW-1:0];
  assign in_addr_ext = alle_pkg::LinkW'(in_i.node_addr);

  // head next link reads null until first written
  assign next_rd = (addr_q == '0 && !head_wr_q) ? alle_pkg::NullLink : next_rdata_i;
  assign next_ok = next_rd < alle_pkg::NullLink;
  assign prev_ok = prev_rdata_i < alle_pkg::NullLink;
  assign succ_ok = succ_q < alle_pkg::NullLink;

  always_comb begin
    st_d = alle_pkg::StBad;
    case (in_i.opcode)
      alle_pkg::OpInsert: begin
        if (in_addr_ext >= alloc_q) begin
          st_d = alle_pkg::StBad;
        end else if (alloc_q >= alle_pkg::NullLink) begin
          st_d = alle_pkg::StFull;
        end else begin
          st_d = alle_pkg::StOk;
        end
      end
      alle_pkg::OpErase, alle_pkg::OpRead: begin
        if (in_i.node_addr == '0 || in_addr_ext >= alloc_q) begin
          st_d = alle_pkg::StBad;
        end else begin
          st_d = alle_pkg::StOk;
        end
      end
      default: st_d = alle_pkg::StBad;
    endcase
  end

  always_comb begin
    state_d    = state_q;
    alloc_d    = alloc_q;
    finish     = 1'b0;
    o_status_d = st_q;
    o_new_d    = '0;
    o_val_d    = '0;
    o_next_d   = '0;
    o_null_d   = 1'b0;
    o_prev_d   = '0;

    next_req_o.re    = accept;
    next_req_o.raddr = in_i.node_addr;
    next_req_o.we    = 1'b0;
    next_req_o.waddr = '0;
    next_req_o.wdata = '0;
    prev_req_o.re    = accept;
    prev_req_o.raddr = in_i.node_addr;
    prev_req_o.we    = 1'b0;
    prev_req_o.waddr = '0;
    prev_req_o.wdata = '0;
    val_req_o.re     = accept;
    val_req_o.raddr  = in_i.node_addr;
    val_req_o.we     = 1'b0;
    val_req_o.waddr  = fresh;
    val_req_o.wdata  = val_q;

    case (state_q)
      SIdle: begin
        if (accept) begin
          state_d = SLink;
        end
      end
      SLink: begin
        if (op_q == alle_pkg::OpInsert && st_q == alle_pkg::StOk) begin
          next_req_o.we    = 1'b1;
          next_req_o.waddr = addr_q;
          next_req_o.wdata = alle_pkg::LinkW'(fresh);
          prev_req_o.we    = 1'b1;
          prev_req_o.waddr = fresh;
          prev_req_o.wdata = alle_pkg::LinkW'(addr_q);
          val_req_o.we     = 1'b1;
          state_d          = SFix;
        end else if (out_free) begin
          finish = 1'b1;
          if (st_q == alle_pkg::StOk && op_q == alle_pkg::OpErase) begin
            next_req_o.we    = prev_ok;
            next_req_o.waddr = prev_rdata_i[alle_pkg::AddrW-1:0];
            next_req_o.wdata = next_rd;
            prev_req_o.we    = next_ok;
            prev_req_o.waddr = next_rd[alle_pkg::AddrW-1:0];
            prev_req_o.wdata = prev_rdata_i;
          end
          if (st_q == alle_pkg::StOk && op_q == alle_pkg::OpRead) begin
            o_val_d  = 32'(val_rdata_i);
            o_next_d = next_ok ? 10'(next_rd[alle_pkg::AddrW-1:0]) : '0;
            o_null_d = !next_ok;
            o_prev_d = prev_ok ? 10'(prev_rdata_i[alle_pkg::AddrW-1:0]) : '0;
          end
          state_d = SIdle;
        end
      end
      SFix: begin
        if (out_free) begin
          finish           = 1'b1;
          next_req_o.we    = 1'b1;
          next_req_o.waddr = fresh;
          next_req_o.wdata = succ_q;
          prev_req_o.we    = succ_ok;
          prev_req_o.waddr = succ_q[alle_pkg::AddrW-1:0];
          prev_req_o.wdata = alloc_q;
          alloc_d          = alloc_q + 1'b1;
          o_new_d          = 10'(fresh);
          state_d          = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      alloc_q     <= alle_pkg::LinkW'(1);
      head_wr_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      alloc_q <= alloc_d;
      if (next_req_o.we && next_req_o.waddr == '0) begin
        head_wr_q <= 1'b1;
      end
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= in_i.opcode;
      addr_q <= in_i.node_addr;
      val_q  <= in_i.item_value[alle_pkg::DataW-1:0];
      st_q   <= st_d;
    end
    if (state_q == SLink) begin
      succ_q <= next_rd;
    end
    if (finish) begin
      o_status_q <= o_status_d;
      o_new_q    <= o_new_d;
      o_val_q    <= o_val_d;
      o_next_q   <= o_next_d;
      o_null_q   <= o_null_d;
      o_prev_q   <= o_prev_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.status       = o_status_q;
  assign out_o.new_node     = o_new_q;
  assign out_o.read_value   = o_val_q;
  assign out_o.next_node    = o_next_q;
  assign out_o.next_is_null = o_null_q;
  assign out_o.prev_node    = o_prev_q;

endmodule

/* dv/tb_array_linked_list_engine.sv */
`timescale 1ns / 1ps

module tb_array_linked_list_engine;

  localparam logic [1:0] OpUnused = 2'd3;
  localparam int NumRandom = 1625;
  localparam int LongHold = 200;

  typedef struct packed {
    logic [1:0]                 status;
    logic [alle_pkg::AddrW-1:0] new_node;
    logic [alle_pkg::DataW-1:0] read_value;
    logic [alle_pkg::AddrW-1:0] next_node;
    logic                       next_is_null;
    logic [alle_pkg::AddrW-1:0] prev_node;
  } list_result_t;

  typedef struct packed {
    logic [1:0]                 op;
    logic [alle_pkg::AddrW-1:0] addr;
    logic [alle_pkg::DataW-1:0] value;
    logic                       typed;
    list_result_t               res;
  } stim_row_t;

  localparam list_result_t NoRes = '0;
  localparam list_result_t BadRes = '{status: alle_pkg::StBad, default: '0};

  localparam stim_row_t DirectedRows [0:24] = '{
    '{alle_pkg::OpRead,   10'd0,    32'd0,         1'b1, BadRes},
    '{alle_pkg::OpErase,  10'd0,    32'd0,         1'b1, BadRes},
    '{alle_pkg::OpInsert, 10'd1,    32'd5,         1'b1, BadRes},
    '{alle_pkg::OpRead,   10'd1,    32'd0,         1'b1, BadRes},
    '{OpUnused,           10'd0,    32'd0,         1'b1, BadRes},
    '{alle_pkg::OpInsert, 10'd0,    32'h7FFF_FFFF, 1'b1,
      '{status: alle_pkg::StOk, new_node: 10'd1, default: '0}},
    '{alle_pkg::OpInsert, 10'd0,    32'h8000_0000, 1'b1,
      '{status: alle_pkg::StOk, new_node: 10'd2, default: '0}},
    '{alle_pkg::OpInsert, 10'd1,    32'hFFFF_FFFF, 1'b1,
      '{status: alle_pkg::StOk, new_node: 10'd3, default: '0}},
    '{alle_pkg::OpRead,   10'd1,    32'd0,         1'b0, NoRes},
    '{alle_pkg::OpRead,   10'd2,    32'd0,         1'b0, NoRes},
    '{alle_pkg::OpRead,   10'd3,    32'd0,         1'b0, NoRes},
    '{alle_pkg::OpErase,  10'd3,    32'd0,         1'b0, NoRes},
    '{alle_pkg::OpErase,  10'd3,    32'd0,         1'b0, NoRes},
    '{alle_pkg::OpRead,   10'd3,    32'd0,         1'b0, NoRes},
    '{alle_pkg::OpErase,  10'd2,    32'd0,         1'b0, NoRes},
    '{alle_pkg::OpRead,   10'd1,    32'd0,         1'b0, NoRes},
    '{alle_pkg::OpInsert, 10'd3,    32'd0,         1'b1,
      '{status: alle_pkg::StOk, new_node: 10'd4, default: '0}},
    '{alle_pkg::OpRead,   10'd4,    32'd0,         1'b0, NoRes},
    '{alle_pkg::OpInsert, 10'd1023, 32'd7,         1'b1, BadRes},
    '{alle_pkg::OpRead,   10'd1023, 32'd0,         1'b1, BadRes},
    '{alle_pkg::OpErase,  10'd5,    32'd0,         1'b1, BadRes},
    '{OpUnused,           10'd1023, 32'hFFFF_FFFF, 1'b1, BadRes},
    '{alle_pkg::OpErase,  10'd1,    32'd0,         1'b0, NoRes},
    '{alle_pkg::OpRead,   10'd4,    32'd0,         1'b0, NoRes},
    '{alle_pkg::OpInsert, 10'd0,    32'd1,         1'b1,
      '{status: alle_pkg::StOk, new_node: 10'd5, default: '0}}
  };

  logic clk_i;
  logic rst_ni;

  alle_in_if  in_ch ();
  alle_out_if out_ch ();

  array_linked_list_engine uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  // list mirror
  logic [alle_pkg::DataW-1:0] node_value [alle_pkg::PoolDepth];
  logic [alle_pkg::LinkW-1:0] next_link  [alle_pkg::PoolDepth];
  logic [alle_pkg::LinkW-1:0] prev_link  [alle_pkg::PoolDepth];
  logic [alle_pkg::LinkW-1:0] alloc_ptr;

  list_result_t pending_results [$];
  list_result_t oldest_result;
  int fail_count;
  int n_insert_ok, n_pool_full, n_bad_addr, n_erase_ok, n_read_ok, n_results;
  bit burst_mode;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic list_result_t apply_list_op(logic [1:0] op,
                                                 logic [alle_pkg::AddrW-1:0] addr,
                                                 logic [alle_pkg::DataW-1:0] value);
    list_result_t res;
    logic [alle_pkg::AddrW-1:0] fresh;
    logic [alle_pkg::LinkW-1:0] succ, pred;
    res = '0;
    res.status = alle_pkg::StOk;
    case (op)
      alle_pkg::OpInsert: begin
        if ({1'b0, addr} >= alloc_ptr) begin
          res.status = alle_pkg::StBad;
        end else if (alloc_ptr >= alle_pkg::NullLink) begin
          res.status = alle_pkg::StFull;
        end else begin
          fresh = alloc_ptr[alle_pkg::AddrW-1:0];
          succ = next_link[addr];
          node_value[fresh] = value;
          if (succ < alle_pkg::NullLink) prev_link[succ[alle_pkg::AddrW-1:0]] = {1'b0, fresh};
          next_link[fresh] = succ;
          next_link[addr] = {1'b0, fresh};
          prev_link[fresh] = {1'b0, addr};
          alloc_ptr = alloc_ptr + 1'b1;
          res.new_node = fresh;
        end
      end
      alle_pkg::OpErase: begin
        if (addr == '0 || {1'b0, addr} >= alloc_ptr) begin
          res.status = alle_pkg::StBad;
        end else begin
          pred = prev_link[addr];
          succ = next_link[addr];
          if (pred < alle_pkg::NullLink) next_link[pred[alle_pkg::AddrW-1:0]] = succ;
          if (succ < alle_pkg::NullLink) prev_link[succ[alle_pkg::AddrW-1:0]] = pred;
        end
      end
      alle_pkg::OpRead: begin
        if (addr == '0 || {1'b0, addr} >= alloc_ptr) begin
          res.status = alle_pkg::StBad;
        end else begin
          succ = next_link[addr];
          pred = prev_link[addr];
          res.read_value = node_value[addr];
          if (succ < alle_pkg::NullLink) res.next_node = succ[alle_pkg::AddrW-1:0];
          else res.next_is_null = 1'b1;
          if (pred < alle_pkg::NullLink) res.prev_node = pred[alle_pkg::AddrW-1:0];
        end
      end
      default: res.status = alle_pkg::StBad;
    endcase
    return res;
  endfunction

  task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
      fail_count++;
    end
  endtask

  // one transaction on the request channel; prediction happens at accept
  task automatic send_op(logic [1:0] op, logic [alle_pkg::AddrW-1:0] addr,
                         logic [alle_pkg::DataW-1:0] value,
                         bit typed, list_result_t typed_res);
    int gap;
    list_result_t res;
    gap = burst_mode ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid      <= 1'b1;
    in_ch.opcode     <= op;
    in_ch.node_addr  <= addr;
    in_ch.item_value <= value;
    do @(posedge clk_i); while (!in_ch.ready);
    res = apply_list_op(op, addr, value);
    if (res.status == alle_pkg::StFull) n_pool_full++;
    else if (res.status == alle_pkg::StBad) n_bad_addr++;
    else if (op == alle_pkg::OpInsert) n_insert_ok++;
    else if (op == alle_pkg::OpErase) n_erase_ok++;
    else n_read_ok++;
    pending_results.push_back(typed ? typed_res : res);
  endtask

  function automatic logic [alle_pkg::DataW-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'hFFFF_FFFF;
      3: return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  // request side
  initial begin
    int sel;
    logic [1:0] op;
    logic [alle_pkg::AddrW-1:0] addr;
    rst_ni           = 1'b0;
    burst_mode       = 1'b0;
    fail_count       = 0;
    in_ch.valid      <= 1'b0;
    in_ch.opcode     <= alle_pkg::OpInsert;
    in_ch.node_addr  <= '0;
    in_ch.item_value <= '0;
    for (int i = 0; i < alle_pkg::PoolDepth; i++) begin
      node_value[i] = '0;
      next_link[i]  = alle_pkg::NullLink;
      prev_link[i]  = alle_pkg::NullLink;
    end
    alloc_ptr = alle_pkg::LinkW'(1);
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DirectedRows[i])
      send_op(DirectedRows[i].op, DirectedRows[i].addr, DirectedRows[i].value,
              DirectedRows[i].typed, DirectedRows[i].res);

    for (int i = 0; i < NumRandom; i++) begin
      if (i % 64 == 0) burst_mode = ($urandom_range(0, 3) == 0);
      if (i == 900) begin
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk_i);
      end
      sel = $urandom_range(0, 99);
      if (sel < 66) begin
        op = alle_pkg::OpInsert;
        addr = alle_pkg::AddrW'($urandom_range(0, alloc_ptr - 1));
      end else if (sel < 95) begin
        op = (sel < 80) ? alle_pkg::OpRead : alle_pkg::OpErase;
        addr = alle_pkg::AddrW'($urandom_range(1, alloc_ptr - 1));
      end else begin
        // noise: any opcode, any address
        op = 2'($urandom_range(0, 3));
        addr = alle_pkg::AddrW'($urandom_range(0, alle_pkg::PoolDepth - 1));
      end
      send_op(op, addr, pick_value(), 1'b0, NoRes);
    end
    in_ch.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    $display("Ran %0d transactions: %0d inserts, %0d erases, %0d reads ok.",
             n_results, n_insert_ok, n_erase_ok, n_read_ok);
    $display("Pool grew to %0d nodes; %0d pool-full and %0d bad-address answers.",
             alloc_ptr - 1, n_pool_full, n_bad_addr);
    if (fail_count == 0) begin
      $display("[array_linked_list_engine] OK");
    end else begin
      $display("[array_linked_list_engine] ERROR");
    end
    $finish;
  end

  // result side backpressure, with one long hold to fill the engine
  initial begin
    int stall;
    int taken;
    bit held;
    taken = 0;
    held = 1'b0;
    out_ch.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = burst_mode ? 0 : $urandom_range(0, 10);
      if (!held && taken >= 400) begin
        stall = LongHold;
        held = 1'b1;
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!out_ch.valid);
      taken++;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      n_results++;
      if (pending_results.size() == 0) begin
        $error("result transaction with no pending request");
        fail_count++;
      end else begin
        oldest_result = pending_results.pop_front();
        check_field("status", 32'(oldest_result.status), 32'(out_ch.status));
        check_field("new_node", 32'(oldest_result.new_node), 32'(out_ch.new_node));
        check_field("read_value", oldest_result.read_value, out_ch.read_value);
        check_field("next_node", 32'(oldest_result.next_node), 32'(out_ch.next_node));
        check_field("next_is_null", 32'(oldest_result.next_is_null),
                    32'(out_ch.next_is_null));
        check_field("prev_node", 32'(oldest_result.prev_node), 32'(out_ch.prev_node));
      end
    end
  end

  initial begin
    #5ms;
    $display("Timeout with %0d results outstanding", pending_results.size());
    $display("[array_linked_list_engine] ERROR");
    $finish;
  end

endmodule
